@@ sv/amb_pkg.sv @@
// ---------------------------------------------------------------------------
// amb_pkg
// Shared types, codes and helpers for the audio Manchester bit recovery block.
// ---------------------------------------------------------------------------
package amb_pkg;

   localparam int COUNT_W     = 16;
   localparam int RATE_W      = 17;
   localparam int SAMPLE_W    = 16;
   localparam int VALUE_W     = 17;
   localparam int LEVEL_W     = 17;
   localparam int THR_W       = 7;
   localparam int SYM_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [SYM_W-1:0] SYM_NONE = 2'd0;
   localparam logic [SYM_W-1:0] SYM_ZERO = 2'd1;
   localparam logic [SYM_W-1:0] SYM_ONE  = 2'd2;

   // half-bit tracking
   localparam logic [1:0] HP_UNSYNC = 2'd0;
   localparam logic [1:0] HP_SYNC   = 2'd1;
   localparam logic [1:0] HP_HALF   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIXTEEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO  = 2'd3;

   localparam logic [RATE_W-1:0] RATE_RESET = 17'd24000;
   localparam logic [RATE_W-1:0] RATE_MIN   = 17'd8000;
   localparam logic [RATE_W-1:0] RATE_MAX   = 17'd96000;

   localparam logic [2:0] K_QUARTER       = 3'd1;
   localparam logic [2:0] K_THREE_QUARTER = 3'd3;
   localparam logic [2:0] K_FIVE_QUARTER  = 3'd5;

   // floor(x / 4800) as (x * RECIP) >> 32, exact for x below 2^19
   localparam logic [19:0] ROUND_ADD = 20'd2400;
   localparam logic [19:0] RECIP     = 20'd894785;

   typedef struct packed {
      logic [1:0]       count;
      logic [SYM_W-1:0] sym_a;
      logic [SYM_W-1:0] sym_b;
   } emit_type;

   function automatic logic [THR_W-1:0] rate_threshold(input logic [RATE_W-1:0] rate,
                                                      input logic [2:0] k);
      logic [RATE_W-1:0] r;
      logic [19:0]       x;
      logic [39:0]       p;
      r = rate;
      if (r < RATE_MIN) begin
         r = RATE_MIN;
      end else if (r > RATE_MAX) begin
         r = RATE_MAX;
      end
      x = 20'(r) * 20'(k) + ROUND_ADD;
      p = 40'(x) * 40'(RECIP);
      return p[38:32];
   endfunction

endpackage

@@ sv/audio_manchester_bit_recovery.sv @@
// ---------------------------------------------------------------------------
// audio_manchester_bit_recovery
// Manchester bit recovery from an audio sample stream.
// a symbol is in the result queue in the cycle after the transfer that causes it
// throughput: one item per cycle while the result queue has room for two
// the result queue holds four symbols and drains one per cycle while rsp_ready is high
// reset: synchronous, 24 kHz rate, 8-bit signed mono, decoder unsynchronized
// ---------------------------------------------------------------------------
module audio_manchester_bit_recovery (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [amb_pkg::SAMPLE_W-1:0]     req_first_channel,
   input  logic [amb_pkg::SAMPLE_W-1:0]     req_second_channel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [amb_pkg::SYM_W-1:0]        rsp_symbol,
   output logic                             rsp_last,
   input  logic                             csr_write,
   input  logic [amb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [amb_pkg::RATE_W-1:0]       csr_wdata
);

   amb_pkg::emit_type emit;
   logic              accept;

   assign accept = req_valid && req_ready;

   amb_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_kind),
      .first_channel  (req_first_channel),
      .second_channel (req_second_channel),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .emit           (emit)
   );

   amb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .space      (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

@@ sv/amb_decode.sv @@
// ---------------------------------------------------------------------------
// amb_decode
// Sample normalization, level filter, polarity tracking and symbol decisions.
// ---------------------------------------------------------------------------
module amb_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                kind,
   input  logic [amb_pkg::SAMPLE_W-1:0]        first_channel,
   input  logic [amb_pkg::SAMPLE_W-1:0]        second_channel,
   input  logic                                csr_write,
   input  logic [amb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [amb_pkg::RATE_W-1:0]          csr_wdata,
   output amb_pkg::emit_type                   emit
);

   logic [amb_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [amb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        pol_ff, pol_in;
   logic [1:0]                  hp_ff, hp_in;
   logic [amb_pkg::THR_W-1:0]   t1_ff, t1_in, t3_ff, t3_in, t5_ff, t5_in;
   logic                        sixteen_ff, signed_ff, stereo_ff;

   logic signed [amb_pkg::VALUE_W-1:0] va, vb, v;
   logic [amb_pkg::VALUE_W-1:0]        mag;
   logic signed [17:0]                 diff, step, lsum, vext, hs;
   logic [amb_pkg::LEVEL_W-1:0]        level_new;
   logic [15:0]                        half, h;
   logic                               p;
   logic [amb_pkg::COUNT_W-1:0]        cinc, c1, c3, c5;

   function automatic logic signed [amb_pkg::VALUE_W-1:0] norm(
      input logic [amb_pkg::SAMPLE_W-1:0] bits,
      input logic                         sixteen,
      input logic                         is_signed);
      logic [15:0] b16;
      logic [7:0]  b8;
      b16 = bits ^ {~is_signed, 15'b0};
      b8  = bits[7:0] ^ {~is_signed, 7'b0};
      if (sixteen) begin
         return {b16[15], b16};
      end
      return {{9{b8[7]}}, b8};
   endfunction

   assign c1 = amb_pkg::COUNT_W'(t1_ff);
   assign c3 = amb_pkg::COUNT_W'(t3_ff);
   assign c5 = amb_pkg::COUNT_W'(t5_ff);

   // sample path
   always_comb begin
      va = norm(first_channel, sixteen_ff, signed_ff);
      vb = norm(second_channel, sixteen_ff, signed_ff);
      v  = stereo_ff ? (va + vb) : va;
      mag = v[amb_pkg::VALUE_W-1] ? amb_pkg::VALUE_W'(-v) : amb_pkg::VALUE_W'(v);
      diff = $signed({1'b0, mag}) - $signed({1'b0, level_ff});
      step = diff >>> 6;
      lsum = $signed({1'b0, level_ff}) + step;
      level_new = lsum[amb_pkg::LEVEL_W-1:0];
      half = level_new[amb_pkg::LEVEL_W-1:1];
      h = (half < 16'd8) ? 16'd8 : half;
      vext = {v[amb_pkg::VALUE_W-1], v};
      hs = $signed({2'b00, h});
      p = pol_ff;
      if (vext > hs) begin
         p = 1'b1;
      end else if (vext < -hs) begin
         p = 1'b0;
      end
      cinc = (count_ff != amb_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      level_in = level_ff;
      count_in = count_ff;
      pol_in   = pol_ff;
      hp_in    = hp_ff;
      t1_in    = t1_ff;
      t3_in    = t3_ff;
      t5_in    = t5_ff;
      emit     = '0;
      if (csr_write && csr_index == amb_pkg::CSR_RATE) begin
         level_in = '0;
         count_in = '0;
         pol_in   = 1'b0;
         hp_in    = amb_pkg::HP_UNSYNC;
         t1_in    = amb_pkg::rate_threshold(csr_wdata, amb_pkg::K_QUARTER);
         t3_in    = amb_pkg::rate_threshold(csr_wdata, amb_pkg::K_THREE_QUARTER);
         t5_in    = amb_pkg::rate_threshold(csr_wdata, amb_pkg::K_FIVE_QUARTER);
      end else if (accept && kind) begin
         // stop: flush final bit, then clear
         if (count_ff < c5) begin
            if (count_ff >= c3) begin
               emit.count = 2'd1;
               emit.sym_a = amb_pkg::SYM_ZERO;
            end else if (count_ff >= c1 && hp_ff != amb_pkg::HP_UNSYNC) begin
               emit.count = 2'd1;
               emit.sym_a = amb_pkg::SYM_ONE;
            end
         end
         level_in = '0;
         count_in = '0;
         pol_in   = 1'b0;
         hp_in    = amb_pkg::HP_UNSYNC;
      end else if (accept) begin
         level_in = level_new;
         count_in = cinc;
         if (p != pol_ff) begin
            pol_in   = p;
            count_in = '0;
            if (cinc < c1) begin
               if (hp_ff != amb_pkg::HP_UNSYNC) begin
                  hp_in      = amb_pkg::HP_UNSYNC;
                  emit.count = 2'd1;
                  emit.sym_a = amb_pkg::SYM_NONE;
               end
            end else if (cinc >= c5) begin
               hp_in = amb_pkg::HP_UNSYNC;
               if (hp_ff == amb_pkg::HP_HALF) begin
                  emit.count = 2'd2;
                  emit.sym_a = amb_pkg::SYM_ONE;
                  emit.sym_b = amb_pkg::SYM_NONE;
               end else begin
                  emit.count = 2'd1;
                  emit.sym_a = amb_pkg::SYM_NONE;
               end
            end else if (cinc >= c3) begin
               hp_in = amb_pkg::HP_SYNC;
               if (hp_ff == amb_pkg::HP_HALF) begin
                  emit.count = 2'd2;
                  emit.sym_a = amb_pkg::SYM_NONE;
                  emit.sym_b = amb_pkg::SYM_ZERO;
               end else begin
                  emit.count = 2'd1;
                  emit.sym_a = amb_pkg::SYM_ZERO;
               end
            end else if (hp_ff != amb_pkg::HP_HALF) begin
               hp_in = amb_pkg::HP_HALF;
            end else begin
               hp_in      = amb_pkg::HP_SYNC;
               emit.count = 2'd1;
               emit.sym_a = amb_pkg::SYM_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         count_ff   <= '0;
         pol_ff     <= 1'b0;
         hp_ff      <= amb_pkg::HP_UNSYNC;
         t1_ff      <= amb_pkg::rate_threshold(amb_pkg::RATE_RESET, amb_pkg::K_QUARTER);
         t3_ff      <= amb_pkg::rate_threshold(amb_pkg::RATE_RESET, amb_pkg::K_THREE_QUARTER);
         t5_ff      <= amb_pkg::rate_threshold(amb_pkg::RATE_RESET, amb_pkg::K_FIVE_QUARTER);
         sixteen_ff <= 1'b0;
         signed_ff  <= 1'b1;
         stereo_ff  <= 1'b0;
      end else begin
         level_ff <= level_in;
         count_ff <= count_in;
         pol_ff   <= pol_in;
         hp_ff    <= hp_in;
         t1_ff    <= t1_in;
         t3_ff    <= t3_in;
         t5_ff    <= t5_in;
         if (csr_write && csr_index == amb_pkg::CSR_SIXTEEN) begin
            sixteen_ff <= csr_wdata[0];
         end
         if (csr_write && csr_index == amb_pkg::CSR_SIGNED) begin
            signed_ff <= csr_wdata[0];
         end
         if (csr_write && csr_index == amb_pkg::CSR_STEREO) begin
            stereo_ff <= csr_wdata[0];
         end
      end
   end

endmodule

@@ sv/amb_fifo.sv @@
// ---------------------------------------------------------------------------
// amb_fifo
// Result queue taking up to two symbols per cycle and giving one per transfer.
// ---------------------------------------------------------------------------
module amb_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  amb_pkg::emit_type          emit,
   output logic                       space,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [amb_pkg::SYM_W-1:0]  rsp_symbol,
   output logic                       rsp_last
);

   logic [amb_pkg::SYM_W-1:0]      sym_ff [amb_pkg::FIFO_DEPTH];
   logic                           last_ff [amb_pkg::FIFO_DEPTH];
   logic [amb_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [amb_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                           pop;

   assign space      = (count_ff <= amb_pkg::FIFO_CNT_W'(amb_pkg::FIFO_DEPTH - 2));
   assign rsp_valid  = (count_ff != '0);
   assign rsp_symbol = sym_ff[rd_ptr_ff];
   assign rsp_last   = last_ff[rd_ptr_ff];
   assign pop        = rsp_valid && rsp_ready;
   assign wr_next    = wr_ptr_ff + 1'b1;

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + amb_pkg::FIFO_PTR_W'(emit.count);
      count_in  = count_ff + amb_pkg::FIFO_CNT_W'(emit.count)
                  - amb_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         sym_ff[wr_ptr_ff]  <= emit.sym_a;
         last_ff[wr_ptr_ff] <= (emit.count == 2'd1);
      end
      if (emit.count == 2'd2) begin
         sym_ff[wr_next]  <= emit.sym_b;
         last_ff[wr_next] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
